// ===== sv/esc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and the floor digit table of the elevator sweep
// controller.
// ----------------------------------------------------------------------------
package esc_pkg;

  // Car geometry
  localparam int unsigned FLOORS     = 4;
  localparam int unsigned FLOOR_W    = 2;
  localparam int unsigned CALL_W     = 4;
  localparam logic [FLOOR_W-1:0] LAST_FLOOR = FLOOR_W'(FLOORS - 1);

  // Field and register widths
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned CAP_W      = 8;
  localparam int unsigned PEOPLE_W   = 8;
  localparam int unsigned SEG_W      = 7;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned CFG_ADDR_W = 2;

  // Register reset values
  localparam logic [TICK_W-1:0] MOTOR_TICKS_RST = 16'd100;
  localparam logic [TICK_W-1:0] DOOR_TICKS_RST  = 16'd600;
  localparam logic [CAP_W-1:0]  CAPACITY_RST    = 8'd4;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_MOTOR_TICKS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DOOR_TICKS  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CAPACITY    = 2'd2;

  // Input word kinds
  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_CALL     = 2'd1,
    ACT_SENSOR_A = 2'd2,
    ACT_SENSOR_B = 2'd3
  } action_t;

  // Car phase
  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_MOVE  = 2'd1,
    PH_DOOR  = 2'd2
  } phase_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_EMIT = 2'd2
  } fsm_t;

  // Seven-segment pattern of a floor digit
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [FLOOR_W-1:0] f);
    logic [SEG_W-1:0] p;
    unique case (f)
      2'd0: p = 7'd63;
      2'd1: p = 7'd6;
      2'd2: p = 7'd91;
      2'd3: p = 7'd79;
      default: p = 7'd63;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== sv/elevator_sweep_controller_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// elevator_sweep_controller_top
// Flow: calls, sensor pulses and non-scanning ticks pass ST_EMIT on the way
// to the output register; a tick that starts a sweep scan first runs ST_SCAN,
// one floor index checked per cycle by the shared compare unit (at most 8).
// Throughput: one word at a time; the next word is taken the cycle after the
// result is loaded into the output register.
// Reset: synchronous, active low; car state, calls, counters and
// configuration return to their reset values.
// ----------------------------------------------------------------------------
module elevator_sweep_controller_top
  import esc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: action [1:0], floor [3:2], zero [7:4]
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // out_tdata: motor_up [0], motor_down [1], door_wait [2], floor_now [4:3],
  //            segments [11:5], people [19:12], overload [20], zero [23:21]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [TICK_W-1:0]     cfg_wdata
);

  fsm_t                fsm_r, fsm_nxt;
  phase_t              phase_r, phase_nxt;
  logic [FLOOR_W-1:0]  car_floor_r, car_floor_nxt;
  logic [CALL_W-1:0]   call_marks_r, call_marks_nxt;
  logic                sweeping_down_r, sweeping_down_nxt;
  logic [FLOOR_W-1:0]  target_r, target_nxt;
  logic [TICK_W-1:0]   wait_count_r, wait_count_nxt;
  logic [PEOPLE_W-1:0] occupancy_r, occupancy_nxt;
  logic                pending_a_r, pending_a_nxt;
  logic                pending_b_r, pending_b_nxt;
  logic                overloaded_r, overloaded_nxt;
  logic [FLOOR_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic                scan_down_r, scan_down_nxt;
  logic [TICK_W-1:0]   motor_ticks_r, door_ticks_r;
  logic [CAP_W-1:0]    capacity_r;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                in_acc;
  action_t             in_action;
  logic [FLOOR_W-1:0]  in_floor;
  logic [TICK_W-1:0]   wc_inc;
  logic [FLOOR_W-1:0]  step_floor;
  logic                do_after;
  logic                go_scan;
  logic                scan_done;
  logic                scan_called;
  logic                hit_up;
  logic                hit_dn;
  logic                out_load;

  assign in_action = action_t'(in_tdata[1:0]);
  assign in_floor  = in_tdata[3:2];
  assign in_acc    = in_tvalid & in_tready;

  // Shared scan compare unit: one floor index against the car per cycle
  assign scan_called = call_marks_r[scan_idx_r];
  assign hit_up      = scan_called & (scan_idx_r > car_floor_r);
  assign hit_dn      = scan_called & (scan_idx_r < car_floor_r);

  // Car, call and occupancy updates
  always_comb begin
    phase_nxt         = phase_r;
    car_floor_nxt     = car_floor_r;
    call_marks_nxt    = call_marks_r;
    sweeping_down_nxt = sweeping_down_r;
    target_nxt        = target_r;
    wait_count_nxt    = wait_count_r;
    occupancy_nxt     = occupancy_r;
    pending_a_nxt     = pending_a_r;
    pending_b_nxt     = pending_b_r;
    overloaded_nxt    = overloaded_r;
    scan_idx_nxt      = scan_idx_r;
    scan_down_nxt     = scan_down_r;
    wc_inc            = wait_count_r + TICK_W'(1);
    step_floor        = car_floor_r;
    do_after          = 1'b0;
    go_scan           = 1'b0;
    scan_done         = 1'b0;
    unique case (fsm_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_action)
            ACT_TICK: begin
              unique case (phase_r)
                PH_MOVE: begin
                  if (wc_inc < motor_ticks_r) begin
                    wait_count_nxt = wc_inc;
                  end else begin
                    wait_count_nxt = '0;
                    if (sweeping_down_r) begin
                      if (car_floor_r != '0) step_floor = car_floor_r - FLOOR_W'(1);
                    end else if (car_floor_r < LAST_FLOOR) begin
                      step_floor = car_floor_r + FLOOR_W'(1);
                    end
                    car_floor_nxt = step_floor;
                    if (call_marks_r[step_floor]) begin
                      phase_nxt = PH_DOOR;
                    end else if (step_floor == target_r) begin
                      do_after = 1'b1;
                    end
                  end
                end
                PH_DOOR: begin
                  if (wc_inc < door_ticks_r) begin
                    wait_count_nxt = wc_inc;
                  end else begin
                    wait_count_nxt = '0;
                    call_marks_nxt = call_marks_r & ~(CALL_W'(1) << car_floor_r);
                    if (car_floor_r == target_r) begin
                      do_after = 1'b1;
                    end else begin
                      phase_nxt = PH_MOVE;
                    end
                  end
                end
                default: begin
                  // Loop start: sweep up from the bottom unless overloaded
                  if (!overloaded_r) begin
                    go_scan       = 1'b1;
                    scan_idx_nxt  = '0;
                    scan_down_nxt = 1'b0;
                  end
                end
              endcase
            end
            ACT_CALL: begin
              if ({1'b0, in_floor} < (FLOOR_W + 1)'(FLOORS)) begin
                call_marks_nxt = call_marks_r | (CALL_W'(1) << in_floor);
              end
            end
            ACT_SENSOR_A: begin
              if (pending_b_r) begin
                if (occupancy_r != '0) occupancy_nxt = occupancy_r - PEOPLE_W'(1);
                pending_b_nxt = 1'b0;
              end else begin
                pending_a_nxt = 1'b1;
              end
              if (occupancy_nxt <= capacity_r) overloaded_nxt = 1'b0;
            end
            ACT_SENSOR_B: begin
              if (pending_a_r) begin
                if (occupancy_r != '1) occupancy_nxt = occupancy_r + PEOPLE_W'(1);
                pending_a_nxt = 1'b0;
              end else begin
                pending_b_nxt = 1'b1;
              end
              if (occupancy_nxt > capacity_r) overloaded_nxt = 1'b1;
            end
            default: ;
          endcase
          // Target reached: continue the sweep from the next index; a down sweep ending at 0 stops
          if (do_after) begin
            if (!sweeping_down_r) begin
              go_scan = 1'b1;
              if (target_r == LAST_FLOOR) begin
                scan_idx_nxt  = LAST_FLOOR;
                scan_down_nxt = 1'b1;
              end else begin
                scan_idx_nxt  = target_r + FLOOR_W'(1);
                scan_down_nxt = 1'b0;
              end
            end else if (target_r == '0) begin
              phase_nxt         = PH_START;
              sweeping_down_nxt = 1'b0;
              target_nxt        = '0;
            end else begin
              go_scan       = 1'b1;
              scan_idx_nxt  = target_r - FLOOR_W'(1);
              scan_down_nxt = 1'b1;
            end
          end
        end
      end
      ST_SCAN: begin
        if (!scan_down_r) begin
          if (hit_up) begin
            phase_nxt         = PH_MOVE;
            target_nxt        = scan_idx_r;
            sweeping_down_nxt = 1'b0;
            wait_count_nxt    = '0;
            scan_done         = 1'b1;
          end else if (scan_idx_r == LAST_FLOOR) begin
            scan_down_nxt = 1'b1;
          end else begin
            scan_idx_nxt = scan_idx_r + FLOOR_W'(1);
          end
        end else begin
          if (hit_dn) begin
            phase_nxt         = PH_MOVE;
            target_nxt        = scan_idx_r;
            sweeping_down_nxt = 1'b1;
            wait_count_nxt    = '0;
            scan_done         = 1'b1;
          end else if (scan_idx_r == '0) begin
            phase_nxt         = PH_START;
            sweeping_down_nxt = 1'b0;
            target_nxt        = '0;
            scan_done         = 1'b1;
          end else begin
            scan_idx_nxt = scan_idx_r - FLOOR_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Sequencer next state
  always_comb begin
    fsm_nxt = fsm_r;
    unique case (fsm_r)
      ST_IDLE: if (in_acc) fsm_nxt = go_scan ? ST_SCAN : ST_EMIT;
      ST_SCAN: if (scan_done) fsm_nxt = ST_EMIT;
      ST_EMIT: if (out_load) fsm_nxt = ST_IDLE;
      default: fsm_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs and output register load
  always_comb begin
    in_tready     = (fsm_r == ST_IDLE);
    out_load      = (fsm_r == ST_EMIT) && (!out_valid_r || out_tready);
    out_valid_nxt = out_load || (out_valid_r && !out_tready);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // State, configuration and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r           <= ST_IDLE;
      phase_r         <= PH_START;
      car_floor_r     <= '0;
      call_marks_r    <= '0;
      sweeping_down_r <= 1'b0;
      target_r        <= '0;
      wait_count_r    <= '0;
      occupancy_r     <= '0;
      pending_a_r     <= 1'b0;
      pending_b_r     <= 1'b0;
      overloaded_r    <= 1'b0;
      scan_idx_r      <= '0;
      scan_down_r     <= 1'b0;
      motor_ticks_r   <= MOTOR_TICKS_RST;
      door_ticks_r    <= DOOR_TICKS_RST;
      capacity_r      <= CAPACITY_RST;
      out_valid_r     <= 1'b0;
    end else begin
      fsm_r           <= fsm_nxt;
      phase_r         <= phase_nxt;
      car_floor_r     <= car_floor_nxt;
      call_marks_r    <= call_marks_nxt;
      sweeping_down_r <= sweeping_down_nxt;
      target_r        <= target_nxt;
      wait_count_r    <= wait_count_nxt;
      occupancy_r     <= occupancy_nxt;
      pending_a_r     <= pending_a_nxt;
      pending_b_r     <= pending_b_nxt;
      overloaded_r    <= overloaded_nxt;
      scan_idx_r      <= scan_idx_nxt;
      scan_down_r     <= scan_down_nxt;
      out_valid_r     <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_MOTOR_TICKS: motor_ticks_r <= cfg_wdata;
          CFG_DOOR_TICKS:  door_ticks_r  <= cfg_wdata;
          CFG_CAPACITY:    capacity_r    <= cfg_wdata[CAP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Capture the result word
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {3'b000,
                     overloaded_r,
                     occupancy_r,
                     seg_pattern(car_floor_r),
                     car_floor_r,
                     (phase_r == PH_DOOR),
                     (phase_r == PH_MOVE) && sweeping_down_r,
                     (phase_r == PH_MOVE) && !sweeping_down_r};
    end
  end

  // Car never leaves the shaft
  a_floor_range: assert property (@(posedge clk) disable iff (!rst_n)
    car_floor_r <= LAST_FLOOR)
    else $error("car floor beyond top floor");

  // Door wait only at a floor whose call is still pending; the served call
  // is already cleared while the scan for the next target runs
  a_door_call: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_DOOR) && (fsm_r != ST_SCAN)) |-> call_marks_r[car_floor_r])
    else $error("door wait without pending call");

  // An accepted word always goes on to scanning or emitting
  a_accept_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (fsm_r == ST_SCAN || fsm_r == ST_EMIT))
    else $error("accepted word not processed");

endmodule
`default_nettype wire

// ===== tb/sv/tb_elevator_sweep_controller_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_elevator_sweep_controller_top
// Self-checking bench for the elevator sweep controller. A table of directed
// words (reset state, sensor pairing, clamp at zero, overload, a full sweep
// with zero and unit intervals) runs first. Random traffic follows under
// several register settings, including the extremes and a fill of the people
// counter past capacity. A local car model predicts each result word not typed
// in by the table. The sender paces in bursts, and the receiver stalls on its
// own pattern with one long hold-off.
// ----------------------------------------------------------------------------
module tb_elevator_sweep_controller_top
  import esc_pkg::*;
;

  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned SETTLE_CYCLES = 12;

  localparam logic [SEG_W-1:0] DIGITS [4] = '{7'd63, 7'd6, 7'd91, 7'd79};

  // Result word as it sits in out_tdata, lowest field last
  typedef struct packed {
    logic [2:0]          pad;
    logic                overload;
    logic [PEOPLE_W-1:0] people;
    logic [SEG_W-1:0]    segments;
    logic [FLOOR_W-1:0]  floor_now;
    logic                door_wait;
    logic                motor_down;
    logic                motor_up;
  } car_view_t;

  typedef enum logic [1:0] {
    ROW_SEND = 2'd0,
    ROW_LIT  = 2'd1,
    ROW_CFG  = 2'd2
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    action_t               act;
    logic [FLOOR_W-1:0]    flr;
    logic [CFG_ADDR_W-1:0] reg_id;
    logic [TICK_W-1:0]     value;
    logic [PEOPLE_W-1:0]   ppl;
    logic                  ovl;
  } step_row_t;

  localparam int unsigned NROWS = 28;

  // Directed walk: ROW_LIT rows carry the idle car view at floor 0 typed in
  localparam step_row_t STEPS [NROWS] = '{
    '{ROW_LIT,  ACT_TICK,     2'd0, '0, '0, 8'd0, 1'b0},
    '{ROW_LIT,  ACT_CALL,     2'd0, '0, '0, 8'd0, 1'b0},
    '{ROW_LIT,  ACT_TICK,     2'd3, '0, '0, 8'd0, 1'b0},
    '{ROW_LIT,  ACT_SENSOR_A, 2'd3, '0, '0, 8'd0, 1'b0},
    '{ROW_LIT,  ACT_SENSOR_B, 2'd0, '0, '0, 8'd1, 1'b0},
    '{ROW_LIT,  ACT_SENSOR_B, 2'd2, '0, '0, 8'd1, 1'b0},
    '{ROW_LIT,  ACT_SENSOR_A, 2'd1, '0, '0, 8'd0, 1'b0},
    '{ROW_LIT,  ACT_SENSOR_B, 2'd0, '0, '0, 8'd0, 1'b0},
    '{ROW_LIT,  ACT_SENSOR_A, 2'd0, '0, '0, 8'd0, 1'b0},
    '{ROW_CFG,  ACT_TICK,     2'd0, CFG_CAPACITY, 16'd0, '0, '0},
    '{ROW_LIT,  ACT_SENSOR_A, 2'd0, '0, '0, 8'd0, 1'b0},
    '{ROW_LIT,  ACT_SENSOR_B, 2'd0, '0, '0, 8'd1, 1'b1},
    '{ROW_LIT,  ACT_CALL,     2'd3, '0, '0, 8'd1, 1'b1},
    '{ROW_LIT,  ACT_TICK,     2'd0, '0, '0, 8'd1, 1'b1},
    '{ROW_LIT,  ACT_SENSOR_B, 2'd0, '0, '0, 8'd1, 1'b1},
    '{ROW_LIT,  ACT_SENSOR_A, 2'd0, '0, '0, 8'd0, 1'b0},
    '{ROW_CFG,  ACT_TICK,     2'd0, CFG_MOTOR_TICKS, 16'd0, '0, '0},
    '{ROW_CFG,  ACT_TICK,     2'd0, CFG_DOOR_TICKS, 16'd1, '0, '0},
    '{ROW_SEND, ACT_TICK,     2'd0, '0, '0, '0, '0},
    '{ROW_SEND, ACT_TICK,     2'd1, '0, '0, '0, '0},
    '{ROW_SEND, ACT_TICK,     2'd2, '0, '0, '0, '0},
    '{ROW_SEND, ACT_TICK,     2'd3, '0, '0, '0, '0},
    '{ROW_SEND, ACT_TICK,     2'd0, '0, '0, '0, '0},
    '{ROW_SEND, ACT_TICK,     2'd0, '0, '0, '0, '0},
    '{ROW_SEND, ACT_TICK,     2'd0, '0, '0, '0, '0},
    '{ROW_SEND, ACT_TICK,     2'd0, '0, '0, '0, '0},
    '{ROW_SEND, ACT_TICK,     2'd0, '0, '0, '0, '0},
    '{ROW_SEND, ACT_CALL,     2'd2, '0, '0, '0, '0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // in_tdata: action [1:0], floor [3:2], zero [7:4]
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  // out_tdata: motor_up [0], motor_down [1], door_wait [2], floor_now [4:3],
  //            segments [11:5], people [19:12], overload [20], zero [23:21]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [TICK_W-1:0]     cfg_wdata;

  // Typed-in expectation travelling with the word on offer
  logic      word_lit;
  car_view_t lit_view;
  logic      squeeze_go;
  int unsigned burst_left;

  int unsigned faults;
  int unsigned results_seen;
  int unsigned quiet_cycles;
  car_view_t   pending_views [$];

  // Car model state and its register copies
  logic [FLOOR_W-1:0]  car_pos;
  logic [CALL_W-1:0]   calls;
  phase_t              car_phase;
  logic                going_down;
  logic [FLOOR_W-1:0]  aim;
  logic [TICK_W-1:0]   dwell;
  logic [PEOPLE_W-1:0] headcount;
  logic                half_a;
  logic                half_b;
  logic                heavy;
  logic [TICK_W-1:0]   run_ticks;
  logic [TICK_W-1:0]   door_hold;
  logic [CAP_W-1:0]    cap_limit;

  elevator_sweep_controller_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------- car model

  function automatic void car_reset();
    car_pos    = '0;
    calls      = '0;
    car_phase  = PH_START;
    going_down = 1'b0;
    aim        = '0;
    dwell      = '0;
    headcount  = '0;
    half_a     = 1'b0;
    half_b     = 1'b0;
    heavy      = 1'b0;
    run_ticks  = MOTOR_TICKS_RST;
    door_hold  = DOOR_TICKS_RST;
    cap_limit  = CAPACITY_RST;
  endfunction

  function automatic void start_trip(input int dest, input logic down);
    car_phase  = PH_MOVE;
    aim        = dest[FLOOR_W-1:0];
    going_down = down;
    dwell      = '0;
  endfunction

  // Look for the next called floor beyond the car, upward first unless told
  function automatic void sweep_scan(input int from, input logic down);
    int  k;
    logic found;
    found = 1'b0;
    k = from;
    if (!down) begin
      while (k < FLOORS && !found) begin
        if (calls[k] && k > car_pos) begin
          start_trip(k, 1'b0);
          found = 1'b1;
        end else begin
          k++;
        end
      end
      k = FLOORS - 1;
    end
    while (k >= 0 && !found) begin
      if (calls[k] && k < car_pos) begin
        start_trip(k, 1'b1);
        found = 1'b1;
      end else begin
        k--;
      end
    end
    if (!found) begin
      car_phase  = PH_START;
      going_down = 1'b0;
      aim        = '0;
    end
  endfunction

  // Carry on the sweep from the index just reached
  function automatic void next_sweep();
    if (!going_down) begin
      sweep_scan(int'(aim) + 1, 1'b0);
    end else if (aim == 0) begin
      sweep_scan(0, 1'b1);
      car_phase  = PH_START;
      going_down = 1'b0;
      aim        = '0;
    end else begin
      sweep_scan(int'(aim) - 1, 1'b1);
    end
  endfunction

  function automatic void run_tick();
    case (car_phase)
      PH_MOVE: begin
        dwell = dwell + 1'b1;
        if (dwell >= run_ticks) begin
          dwell = '0;
          if (going_down) begin
            if (car_pos != 0) car_pos = car_pos - 1'b1;
          end else if (car_pos != LAST_FLOOR) begin
            car_pos = car_pos + 1'b1;
          end
          if (calls[car_pos]) car_phase = PH_DOOR;
          else if (car_pos == aim) next_sweep();
        end
      end
      PH_DOOR: begin
        dwell = dwell + 1'b1;
        if (dwell >= door_hold) begin
          dwell = '0;
          calls[car_pos] = 1'b0;
          if (car_pos == aim) next_sweep();
          else car_phase = PH_MOVE;
        end
      end
      default: begin
        if (!heavy) sweep_scan(0, 1'b0);
      end
    endcase
  endfunction

  function automatic car_view_t car_advance(input action_t act, input logic [FLOOR_W-1:0] flr);
    car_view_t v;
    case (act)
      ACT_TICK: run_tick();
      ACT_CALL: calls[flr] = 1'b1;
      ACT_SENSOR_A: begin
        if (half_b) begin
          if (headcount != 0) headcount = headcount - 1'b1;
          half_b = 1'b0;
        end else begin
          half_a = 1'b1;
        end
        if (headcount <= cap_limit) heavy = 1'b0;
      end
      default: begin
        if (half_a) begin
          if (headcount != 8'd255) headcount = headcount + 1'b1;
          half_a = 1'b0;
        end else begin
          half_b = 1'b1;
        end
        if (headcount > cap_limit) heavy = 1'b1;
      end
    endcase
    v            = '0;
    v.motor_up   = (car_phase == PH_MOVE) && !going_down;
    v.motor_down = (car_phase == PH_MOVE) && going_down;
    v.door_wait  = (car_phase == PH_DOOR);
    v.floor_now  = car_pos;
    v.segments   = DIGITS[car_pos];
    v.people     = headcount;
    v.overload   = heavy;
    return v;
  endfunction

  function automatic car_view_t idle_view(input logic [PEOPLE_W-1:0] ppl, input logic ovl);
    car_view_t v;
    v          = '0;
    v.segments = DIGITS[0];
    v.people   = ppl;
    v.overload = ovl;
    return v;
  endfunction

  // ------------------------------------------------------------------ checker

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    faults++;
    $display("mismatch in %s at result %0d: got %0h, expected %0h",
             what, results_seen, got, want);
  endtask

  task automatic compare_view(input car_view_t got, input car_view_t want);
    if (got.motor_up !== want.motor_up)     report("motor_up", got.motor_up, want.motor_up);
    if (got.motor_down !== want.motor_down) report("motor_down", got.motor_down, want.motor_down);
    if (got.door_wait !== want.door_wait)   report("door_wait", got.door_wait, want.door_wait);
    if (got.floor_now !== want.floor_now)   report("floor_now", got.floor_now, want.floor_now);
    if (got.segments !== want.segments)     report("segments", got.segments, want.segments);
    if (got.people !== want.people)         report("people", got.people, want.people);
    if (got.overload !== want.overload)     report("overload", got.overload, want.overload);
    if (got.pad !== want.pad)               report("zero fill", got.pad, want.pad);
  endtask

  // Track register writes, predict each accepted word, check each result word
  always @(posedge clk) begin : watch_ports
    car_view_t seen;
    car_view_t pred;
    if (!rst_n) begin
      car_reset();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_MOTOR_TICKS: run_ticks = cfg_wdata;
          CFG_DOOR_TICKS:  door_hold = cfg_wdata;
          CFG_CAPACITY:    cap_limit = cfg_wdata[CAP_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        seen = car_view_t'(out_tdata);
        if (pending_views.size() == 0) report("unexpected word", out_tdata, '0);
        else compare_view(seen, pending_views.pop_front());
      end
      if (in_tvalid && in_tready) begin
        pred = car_advance(action_t'(in_tdata[1:0]), in_tdata[3:2]);
        pending_views.push_back(word_lit ? lit_view : pred);
      end
    end
  end

  // Count cycles with no word moving; give up at the limit
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_elevator_sweep_controller_top NOT OK");
      $finish;
    end
  end

  // ----------------------------------------------------------------- receiver

  // Rotate between always ready, random stalls and a fixed stall pattern;
  // hold off once for a long stretch when asked
  initial begin : receiver
    int unsigned beat;
    logic        squeezed;
    int unsigned mode;
    out_tready = 1'b0;
    beat       = 0;
    squeezed   = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_go && !squeezed) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        squeezed = 1'b1;
      end else begin
        mode = (beat / 48) % 3;
        if (mode == 0) out_tready <= 1'b1;
        else if (mode == 1) out_tready <= ($urandom_range(0, 3) != 0);
        else out_tready <= ((beat % 5) >= 2);
        beat++;
      end
    end
  end

  // ------------------------------------------------------------------- sender

  // Offer one word, pacing in bursts with random gaps between them
  task automatic offer(input action_t act, input logic [FLOOR_W-1:0] flr,
                       input logic lit, input car_view_t view);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, flr, act};
    word_lit  <= lit;
    lit_view  <= view;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic offer_plain(input action_t act, input logic [FLOOR_W-1:0] flr);
    offer(act, flr, 1'b0, '0);
  endtask

  // Drop valid and wait until every result word is back
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [TICK_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly ticks and calls plus well-formed sensor pairs, some lone pulses
  task automatic random_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        offer_plain(ACT_TICK, FLOOR_W'($urandom));
        sent++;
      end else if (pick < 65) begin
        offer_plain(ACT_CALL, FLOOR_W'($urandom));
        sent++;
      end else if (pick < 90) begin
        if ($urandom_range(0, 1) != 0) begin
          offer_plain(ACT_SENSOR_A, FLOOR_W'($urandom));
          offer_plain(ACT_SENSOR_B, FLOOR_W'($urandom));
        end else begin
          offer_plain(ACT_SENSOR_B, FLOOR_W'($urandom));
          offer_plain(ACT_SENSOR_A, FLOOR_W'($urandom));
        end
        sent += 2;
      end else begin
        offer_plain(($urandom_range(0, 1) != 0) ? ACT_SENSOR_A : ACT_SENSOR_B,
                    FLOOR_W'($urandom));
        sent++;
      end
    end
  endtask

  task automatic run_phase(input logic [TICK_W-1:0] motor, input logic [TICK_W-1:0] door,
                           input logic [CAP_W-1:0] cap, input int unsigned count);
    settle();
    write_reg(CFG_MOTOR_TICKS, motor);
    write_reg(CFG_DOOR_TICKS, door);
    write_reg(CFG_CAPACITY, TICK_W'(cap));
    random_traffic(count);
  endtask

  initial begin : stimulus
    int unsigned r;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    word_lit   = 1'b0;
    lit_view   = '0;
    squeeze_go = 1'b0;
    burst_left = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (r = 0; r < NROWS; r++) begin
      if (STEPS[r].kind == ROW_CFG) begin
        settle();
        write_reg(STEPS[r].reg_id, STEPS[r].value);
      end else begin
        offer(STEPS[r].act, STEPS[r].flr, STEPS[r].kind == ROW_LIT,
              idle_view(STEPS[r].ppl, STEPS[r].ovl));
      end
    end

    // Random traffic; the first phase backs up the block with a long hold-off
    settle();
    write_reg(CFG_MOTOR_TICKS, 16'd1);
    write_reg(CFG_DOOR_TICKS, 16'd1);
    write_reg(CFG_CAPACITY, 16'd2);
    squeeze_go = 1'b1;
    random_traffic(70);
    run_phase(16'd3, 16'd2, 8'd0, 60);
    run_phase(16'hFFFF, 16'hFFFF, 8'd254, 25);
    // Intervals drop below the running count left by the slow phase
    run_phase(16'd2, 16'd0, 8'd1, 60);

    // Fill the people counter past capacity, then walk back under it
    settle();
    write_reg(CFG_MOTOR_TICKS, 16'd1);
    write_reg(CFG_DOOR_TICKS, 16'd1);
    write_reg(CFG_CAPACITY, 16'd20);
    repeat (24) begin
      offer_plain(ACT_SENSOR_A, FLOOR_W'($urandom));
      offer_plain(ACT_SENSOR_B, FLOOR_W'($urandom));
    end
    repeat (4) begin
      offer_plain(ACT_SENSOR_B, FLOOR_W'($urandom));
      offer_plain(ACT_SENSOR_A, FLOOR_W'($urandom));
    end

    repeat (3) begin
      run_phase(TICK_W'($urandom_range(0, 4)), TICK_W'($urandom_range(0, 4)),
                CAP_W'($urandom_range(0, 5)), 35);
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (faults == 0) begin
      $display("tb_elevator_sweep_controller_top OK");
    end else begin
      $display("tb_elevator_sweep_controller_top NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
